/* rtl/m4mu_pkg.sv */
// Shared constants and types for the 4x4 fixed-point matrix multiply unit.
package m4mu_pkg;

	// Element format: signed Q16.16
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;

	// Matrix size and derived index widths
	localparam int DIM     = 4;
	localparam int IDX_W   = $clog2(DIM);
	localparam int CNT_W   = 2 * IDX_W;

	// Full-width product and the accumulator that holds DIM of them
	localparam int PROD_W  = 2 * DATA_W;
	localparam int ACC_W   = PROD_W + IDX_W;

	// Stream payload widths
	localparam int IN_W    = 2 * DIM * DATA_W;
	localparam int OUT_W   = DIM * DATA_W;
	localparam int OUSER_W = IDX_W + 1;

	// One matrix row of elements
	typedef logic [DIM-1:0][DATA_W-1:0] row_t;

	// Per-step control that travels into each MAC lane
	typedef struct packed {
		logic valid;
		logic first;
	} lane_ctl_t;

	// Finished element from one lane
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              sat;
	} lane_res_t;

	typedef lane_res_t [DIM-1:0] lane_res_vec_t;

endpackage

/* rtl/matrix4x4_multiply_unit.sv */
// Top level of the 4x4 Q16.16 matrix multiply unit with four parallel MAC lanes.
// After the row-3 transaction, products pass the store read, multiply, accumulate, saturate and output registers.
// Each input transaction loads one row of both matrices; each product row comes from the
// four-step multiply-accumulate in each of the four column lanes.
// s_tready stays low from the row-3 transaction until the last product row is taken.
// Reset clears control state only; stored matrix rows are undefined until written.
module matrix4x4_multiply_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [m4mu_pkg::IN_W-1:0]    s_tdata,   // a_col0..a_col3, b_col0..b_col3
	input  logic [m4mu_pkg::IDX_W-1:0]   s_tuser,   // row_sel
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [m4mu_pkg::OUT_W-1:0]   m_tdata,   // c_col0, c_col1, c_col2, c_col3
	output logic [m4mu_pkg::OUSER_W-1:0] m_tuser,   // out_row[1:0], overflow
	output logic                         m_tlast
);
	import m4mu_pkg::*;

	logic             accept;
	logic             trigger;
	logic             en;
	logic             busy_q;
	logic             issue_q;
	logic [CNT_W-1:0] cnt_q;
	logic             issue_fire;
	row_t             wr_a;
	row_t             wr_b;
	row_t             rd_a;
	row_t             rd_b;
	logic             valid_s1;
	logic [IDX_W-1:0] k_s1;
	lane_ctl_t        ctl_s1;
	logic             done_s2;
	logic             done_s3;
	logic             done_s4;
	lane_res_vec_t    lanes;

	// Input transaction and trigger on the last row
	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign trigger  = accept && (s_tuser == IDX_W'(DIM - 1));

	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			wr_a[j] = s_tdata[j*DATA_W +: DATA_W];
			wr_b[j] = s_tdata[(DIM + j)*DATA_W +: DATA_W];
		end
	end

	// Whole compute pipeline advances only when the output register can take data
	assign issue_fire = issue_q && en;

	m4mu_store u_store (
		.clk       (clk),
		.wr_en     (accept),
		.wr_row    (s_tuser),
		.wr_a      (wr_a),
		.wr_b      (wr_b),
		.rd_en     (issue_fire),
		.rd_a_addr (cnt_q[CNT_W-1:IDX_W]),
		.rd_b_addr (cnt_q[IDX_W-1:0]),
		.rd_a      (rd_a),
		.rd_b      (rd_b)
	);

	// Sequencer: busy flag and step counter (product row, inner index)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (trigger) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				cnt_q   <= '0;
			end else begin
				if (m_tvalid && m_tready && m_tlast) begin
					busy_q <= 1'b0;
				end
				if (issue_fire) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == {CNT_W{1'b1}}) begin
						issue_q <= 1'b0;
					end
				end
			end
		end
	end

	// Step tags alongside the read data, and row-done chain to the merge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			k_s1     <= '0;
			done_s2  <= 1'b0;
			done_s3  <= 1'b0;
			done_s4  <= 1'b0;
		end else if (en) begin
			valid_s1 <= issue_q;
			k_s1     <= cnt_q[IDX_W-1:0];
			done_s2  <= valid_s1 && (k_s1 == IDX_W'(DIM - 1));
			done_s3  <= done_s2;
			done_s4  <= done_s3;
		end
	end

	assign ctl_s1.valid = valid_s1;
	assign ctl_s1.first = (k_s1 == '0);

	// One lane per product column; all share A[r][k]
	for (genvar j = 0; j < DIM; j++) begin : g_lane
		m4mu_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl    (ctl_s1),
			.a_elem (rd_a[k_s1]),
			.b_elem (rd_b[j]),
			.res    (lanes[j])
		);
	end

	m4mu_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (done_s4),
		.lanes    (lanes),
		.out_free (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// No input is taken while product rows are pending
	a_no_accept_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a product row is pending");

	// Taking the final product row frees the input
	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("input not ready after final product row");

	// A trigger always starts the step sequence from the first step
	a_trigger_starts: assert property (@(posedge clk) disable iff (!arst_n)
		trigger |=> (issue_q && cnt_q == '0))
		else $error("trigger did not start compute");

	// Row numbering restarts at zero for every product
	a_row_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (m_tuser[IDX_W-1:0] == '0))
		else $error("product row counter not at zero while idle");

endmodule

/* rtl/m4mu_store.sv */
// Row-wide storage for the left and right matrices, one row per word.
module m4mu_store (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [m4mu_pkg::IDX_W-1:0]  wr_row,
	input  m4mu_pkg::row_t              wr_a,
	input  m4mu_pkg::row_t              wr_b,
	input  logic                        rd_en,
	input  logic [m4mu_pkg::IDX_W-1:0]  rd_a_addr,
	input  logic [m4mu_pkg::IDX_W-1:0]  rd_b_addr,
	output m4mu_pkg::row_t              rd_a,
	output m4mu_pkg::row_t              rd_b
);
	import m4mu_pkg::*;

	row_t a_mem [DIM];
	row_t b_mem [DIM];

	// Write one row of each matrix per transaction
	always_ff @(posedge clk) begin
		if (wr_en) begin
			a_mem[wr_row] <= wr_a;
			b_mem[wr_row] <= wr_b;
		end
	end

	// Registered read: A row r and B row k for the current step
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a <= a_mem[rd_a_addr];
			rd_b <= b_mem[rd_b_addr];
		end
	end

endmodule

/* rtl/m4mu_lane.sv */
// One multiply-accumulate lane: computes a single product element over DIM steps.
module m4mu_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  m4mu_pkg::lane_ctl_t          ctl,
	input  logic [m4mu_pkg::DATA_W-1:0]  a_elem,
	input  logic [m4mu_pkg::DATA_W-1:0]  b_elem,
	output m4mu_pkg::lane_res_t          res
);
	import m4mu_pkg::*;

	logic signed [PROD_W-1:0]  prod_s2;
	lane_ctl_t                 ctl_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   sh;
	logic [ACC_W-DATA_W:0]     upper;
	logic                      fits;
	lane_res_t                 res_s4;

	// Multiply stage
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PROD_W'(signed'(a_elem)) * PROD_W'(signed'(b_elem));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl;
		end
	end

	// Accumulate at full width; the first step restarts the sum
	always_ff @(posedge clk) begin
		if (en && ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// Drop fraction bits and saturate to the element width
	always_comb begin
		sh    = acc_q >>> FRAC_BITS;
		upper = sh[ACC_W-1:DATA_W-1];
		fits  = (&upper) || !(|upper);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fits) begin
				res_s4.value <= sh[DATA_W-1:0];
			end else if (sh[ACC_W-1]) begin
				res_s4.value <= {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				res_s4.value <= {1'b0, {(DATA_W-1){1'b1}}};
			end
			res_s4.sat <= !fits;
		end
	end

	assign res = res_s4;

endmodule

/* rtl/m4mu_merge.sv */
// Output stage: gathers the lane elements into one product row transaction.
module m4mu_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  m4mu_pkg::lane_res_vec_t      lanes,
	output logic                         out_free,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [m4mu_pkg::OUT_W-1:0]   m_tdata,   // c_col0, c_col1, c_col2, c_col3
	output logic [m4mu_pkg::OUSER_W-1:0] m_tuser,   // out_row[1:0], overflow
	output logic                         m_tlast
);
	import m4mu_pkg::*;

	logic                valid_q;
	logic [IDX_W-1:0]    row_q;
	logic [OUT_W-1:0]    data_q;
	logic                ovf_q;
	logic [OUT_W-1:0]    data_d;
	logic                ovf_d;

	assign out_free = !valid_q || m_tready;

	// Pack lane values and fold the saturation flags
	always_comb begin
		ovf_d = 1'b0;
		for (int j = 0; j < DIM; j++) begin
			data_d[j*DATA_W +: DATA_W] = lanes[j].value;
			ovf_d = ovf_d | lanes[j].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && in_valid) begin
			data_q <= data_d;
			ovf_q  <= ovf_d;
		end
	end

	// Output valid and product row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			row_q   <= '0;
		end else begin
			if (valid_q && m_tready) begin
				row_q <= row_q + IDX_W'(1);
			end
			if (out_free) begin
				valid_q <= in_valid;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = {ovf_q, row_q};
	assign m_tlast  = (row_q == IDX_W'(DIM - 1));

endmodule
